### sv/sce_pkg.sv
// ----------------------------------------------------------------------------
// sce_pkg - shared constants for the seam cumulative energy block
// Field widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package sce_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned MAX_COLUMNS_DEF  = 4096;
  localparam int unsigned ENERGY_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int unsigned PIXEL_W   = 16;  // pixel energy
  localparam int unsigned PARENT_W  = 13;  // signed parent column
  localparam int unsigned NCOL_W    = 13;  // num_columns register
  localparam int unsigned NROW_W    = 16;  // num_rows register
  localparam int unsigned MARGIN_W  = 32;  // margin_energy register
  localparam int unsigned IN_DATA_W = 16;  // input tdata, whole bytes

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_ENERGY = 2'd2;

  // Register reset values
  localparam logic [NCOL_W-1:0]   NUM_COLUMNS_RST   = 13'd1920;
  localparam logic [NROW_W-1:0]   NUM_ROWS_RST      = 16'd1080;
  localparam logic [MARGIN_W-1:0] MARGIN_ENERGY_RST = 32'd0;

endpackage : sce_pkg

`default_nettype wire

### sv/sce_ram.sv
// ----------------------------------------------------------------------------
// sce_ram - simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : sce_ram

`default_nettype wire

### sv/seam_cumulative_energy.sv
// ----------------------------------------------------------------------------
// seam_cumulative_energy - vertical seam cumulative energy, one pixel a beat
// Pixels enter in raster order; each leaves with its path energy and parent.
// ----------------------------------------------------------------------------
// Rate: one pixel per clock unless results stall, no bubbles at row and frame
// boundaries. Each pixel passes one register stage: an accepted input beat
// produces its result beat on the next cycle, held in an output register that
// decouples the two stream sides (input ready = output empty or being taken).
// The previous row lives in a line buffer RAM (MAX_COLUMNS x ENERGY_WIDTH+1)
// that is written at the current column and read two columns ahead, so the
// above-right neighbor is ready when the next pixel arrives; the above
// neighbor is the old above-right, the above-left the old above. Columns 0 and
// 1 of each new row are also kept in flops, which seeds the first pixel of the
// next row without a second read port and covers rows of one or two pixels.
// The per-pixel datapath is three compares in preference order (above,
// above-right, above-left, strict less-than, marked or infinite parents
// skipped) and one saturating add. All-ones total means infinity; parent -1
// means none. Configuration is taken at any time but must be written while no
// pixel is in flight; a line buffer entry never written since reset reads
// undefined. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module seam_cumulative_energy
  import sce_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS  = MAX_COLUMNS_DEF,
  parameter int unsigned ENERGY_WIDTH = ENERGY_WIDTH_DEF,
  localparam int unsigned OUT_DATA_W  = ((ENERGY_WIDTH + PARENT_W + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // Pixel input stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // [15:0] pixel_energy
  input  wire logic                  s_axis_tuser_i,   // pixel_marked
  // Result stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,   // total_energy, parent_column, 0 pad
  output logic                       m_axis_tlast_o    // frame_last
);

  localparam int unsigned EW    = ENERGY_WIDTH;
  localparam int unsigned COL_W = $clog2(MAX_COLUMNS);
  // Compare width covering the column counter + 1 and the num_columns register
  localparam int unsigned CMP_W = (COL_W + 1 > NCOL_W) ? COL_W + 1 : NCOL_W;
  localparam int unsigned PAD_W = OUT_DATA_W - EW - PARENT_W;
  localparam logic [EW-1:0] INF = {EW{1'b1}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [NCOL_W-1:0]   num_columns_q;
  logic [NROW_W-1:0]   num_rows_q;
  logic [MARGIN_W-1:0] margin_energy_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_columns_q   <= NUM_COLUMNS_RST;
      num_rows_q      <= NUM_ROWS_RST;
      margin_energy_q <= MARGIN_ENERGY_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_NUM_COLUMNS:   num_columns_q   <= cfg_data_i[NCOL_W-1:0];
        REG_NUM_ROWS:      num_rows_q      <= cfg_data_i[NROW_W-1:0];
        REG_MARGIN_ENERGY: margin_energy_q <= cfg_data_i[MARGIN_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Position and neighbor window state
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]  col_q;
  logic [NROW_W-1:0] row_q;
  logic              row_start_q;     // next pixel is column 0: use row0/row1 flops
  logic [EW-1:0]     left_e_q;        // above-left
  logic              left_m_q;
  logic [EW-1:0]     above_e_q;       // above, valid when not at row start
  logic              above_m_q;
  logic [EW-1:0]     row0_e_q;        // last value written to column 0
  logic              row0_m_q;
  logic [EW-1:0]     row1_e_q;        // last value written to column 1
  logic              row1_m_q;

  // Output register
  logic                out_valid_q;
  logic [EW-1:0]       out_total_q;
  logic [PARENT_W-1:0] out_parent_q;
  logic                out_last_q;

  logic                accept;
  logic [CMP_W-1:0]    cols_eff;
  logic [NROW_W:0]     rows_eff;
  logic                last_col;
  logic                last_row;
  logic [EW:0]         ram_rdata;
  logic [EW-1:0]       cur_above_e;
  logic                cur_above_m;
  logic [EW-1:0]       cur_right_e;
  logic                cur_right_m;
  logic [PIXEL_W-1:0]  pix_energy;
  logic                pix_marked;
  logic [EW-1:0]       best;
  logic                found;
  logic [COL_W:0]      parent_wide;
  logic [EW:0]         sum;
  logic [EW-1:0]       total;
  logic [PARENT_W-1:0] parent;
  logic [COL_W-1:0]    rd_addr;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pix_energy      = s_axis_tdata_i[PIXEL_W-1:0];
  assign pix_marked      = s_axis_tuser_i;

  // Effective geometry: zero acts as one, columns capped at the buffer depth
  always_comb begin
    if (num_columns_q == '0) begin
      cols_eff = CMP_W'(1);
    end else if (CMP_W'(num_columns_q) > CMP_W'(MAX_COLUMNS)) begin
      cols_eff = CMP_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CMP_W'(num_columns_q);
    end
    rows_eff = (num_rows_q == '0) ? (NROW_W+1)'(1) : {1'b0, num_rows_q};
  end

  assign last_col = (CMP_W'(col_q) + CMP_W'(1)) >= cols_eff;
  assign last_row = ({1'b0, row_q} + (NROW_W+1)'(1)) >= rows_eff;

  // Neighbor sources
  assign cur_above_e = row_start_q ? row0_e_q : above_e_q;
  assign cur_above_m = row_start_q ? row0_m_q : above_m_q;
  assign cur_right_e = row_start_q ? row1_e_q : ram_rdata[EW-1:0];
  assign cur_right_m = row_start_q ? row1_m_q : ram_rdata[EW];

  // Parent choice: above, then above-right, then above-left, strict less-than
  always_comb begin
    best        = INF;
    found       = 1'b0;
    parent_wide = {1'b0, col_q};
    if (!cur_above_m && (cur_above_e < best)) begin
      best        = cur_above_e;
      found       = 1'b1;
      parent_wide = {1'b0, col_q};
    end
    if (!last_col && !cur_right_m && (cur_right_e < best)) begin
      best        = cur_right_e;
      found       = 1'b1;
      parent_wide = {1'b0, col_q} + (COL_W+1)'(1);
    end
    if ((col_q != '0) && !left_m_q && (left_e_q < best)) begin
      best        = left_e_q;
      found       = 1'b1;
      parent_wide = {1'b0, col_q} - (COL_W+1)'(1);
    end
  end

  assign sum = {1'b0, best} + {{(EW + 1 - PIXEL_W){1'b0}}, pix_energy};

  always_comb begin
    total  = INF;
    parent = {PARENT_W{1'b1}};
    if (row_q == '0) begin
      // top row: margin, no parent
      total = pix_marked ? INF : EW'(margin_energy_q);
    end else if (!pix_marked && found) begin
      total  = (sum >= {1'b0, INF}) ? INF - EW'(1) : sum[EW-1:0];
      parent = PARENT_W'(parent_wide);
    end
  end

  // Read two columns ahead: above-right of the next pixel in this row
  assign rd_addr = col_q + COL_W'(2);

  sce_ram #(
    .WIDTH (EW + 1),
    .DEPTH (MAX_COLUMNS)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i ({pix_marked, total}),
    .re_i    (accept && !last_col),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      row_start_q <= 1'b1;
      left_e_q    <= INF;
      left_m_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        left_e_q <= cur_above_e;
        left_m_q <= cur_above_m;
        if (last_col) begin
          col_q       <= '0;
          row_q       <= last_row ? '0 : row_q + NROW_W'(1);
          row_start_q <= 1'b1;
        end else begin
          col_q       <= col_q + COL_W'(1);
          row_start_q <= 1'b0;
        end
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!last_col) begin
        above_e_q <= cur_right_e;
        above_m_q <= cur_right_m;
      end
      if (col_q == COL_W'(0)) begin
        row0_e_q <= total;
        row0_m_q <= pix_marked;
      end
      if (col_q == COL_W'(1)) begin
        row1_e_q <= total;
        row1_m_q <= pix_marked;
      end
      out_total_q  <= total;
      out_parent_q <= parent;
      out_last_q   <= last_col && last_row;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, out_parent_q, out_total_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule : seam_cumulative_energy

`default_nettype wire

### dv/tb_seam_cumulative_energy.sv
// ----------------------------------------------------------------------------
// tb_seam_cumulative_energy - self-checking bench for the seam energy block
// A directed table, then random frames of pixels with register changes made
// while idle. Every result beat is matched to a typed or predicted value.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_seam_cumulative_energy;
  import sce_pkg::*;

  localparam int unsigned MAXC          = MAX_COLUMNS_DEF;
  localparam int unsigned EW            = ENERGY_WIDTH_DEF;
  localparam int unsigned OUT_W         = ((EW + PARENT_W + 7) / 8) * 8;
  localparam logic [EW-1:0] INF         = '1;        // all-ones energy code
  localparam logic [PARENT_W-1:0] NO_PARENT = '1;    // parent -1
  localparam int unsigned RANDOM_PIXELS = 650;
  localparam int unsigned CALM_PIXELS   = 90;        // tail with no idling
  localparam int unsigned SETTLE_CYCLES = 3;         // one register stage, plus margin
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;

  typedef struct packed {
    logic [EW-1:0]       total;
    logic [PARENT_W-1:0] parent;
    logic                last;
  } seam_result_t;

  typedef enum bit {ROW_PIXEL, ROW_WRITE} plan_kind_e;

  typedef struct {
    plan_kind_e           kind;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] value;
    logic [PIXEL_W-1:0]   energy;
    bit                   marked;
    bit                   typed;   // want is typed in, else predicted
    seam_result_t         want;
  } plan_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  px_valid  = 1'b0;
  logic                  px_ready;
  logic [IN_DATA_W-1:0]  px_data   = '0;
  logic                  px_marked = 1'b0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  logic [OUT_W-1:0]      res_data;
  logic                  res_last;

  initial begin
    forever #5 clk = ~clk;
  end

  seam_cumulative_energy DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (px_valid),
    .s_axis_tready_o (px_ready),
    .s_axis_tdata_i  (px_data),
    .s_axis_tuser_i  (px_marked),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data),
    .m_axis_tlast_o  (res_last)
  );

  // --------------------------------------------------------------------------
  // Predictor state: own copy of registers, line buffer, window and counters
  // --------------------------------------------------------------------------
  logic [NCOL_W-1:0]   reg_cols   = NUM_COLUMNS_RST;
  logic [NROW_W-1:0]   reg_rows   = NUM_ROWS_RST;
  logic [MARGIN_W-1:0] reg_margin = MARGIN_ENERGY_RST;

  logic [EW-1:0] line_energy  [MAXC];
  bit            line_marked  [MAXC];
  bit            line_written [MAXC];   // touched since reset
  logic [EW-1:0] win_energy   [3];      // above-left, above, above-right
  bit            win_marked   [3];
  int unsigned   col_cnt = 0;
  int unsigned   row_cnt = 0;

  seam_result_t pending_results [$];    // oldest first
  seam_result_t want_now;
  int unsigned  mismatches = 0;
  int unsigned  cycles     = 0;
  int unsigned  stall_left = 0;
  bit           idle_on    = 1'b1;
  bit           calm       = 1'b0;
  bit           cfg_held   = 1'b0;      // cfg_valid still high after a beat
  plan_row_t    plan [$];

  function automatic int unsigned eff_columns(input logic [NCOL_W-1:0] value);
    if (value == 0) return 1;
    if (value > MAXC) return MAXC;
    return value;
  endfunction

  // Would a column count never read a line buffer entry that was never written?
  // In the top row nothing read is used, and the row writes every column first.
  function automatic bit cols_ok(input logic [NCOL_W-1:0] value);
    int unsigned n;
    n = eff_columns(value);
    if (row_cnt == 0) return 1'b1;
    for (int unsigned i = 0; i < n; i++)
      if (!line_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Path energy of one pixel; advances the predictor state.
  function automatic seam_result_t predict_path(input logic [PIXEL_W-1:0] energy,
                                                input bit marked);
    seam_result_t r;
    int unsigned  cols, rows, c;
    bit           lc, lr, found;
    logic [EW-1:0] best, total, e_ext;
    logic [PARENT_W-1:0] parent;
    cols  = eff_columns(reg_cols);
    rows  = (reg_rows == 0) ? 1 : reg_rows;
    c     = (col_cnt >= MAXC) ? MAXC - 1 : col_cnt;   // counter past a shrunk row
    lc    = (c + 1 >= cols);
    lr    = (row_cnt + 1 >= rows);
    e_ext = EW'(energy);

    win_energy[1] = line_energy[c];
    win_marked[1] = line_marked[c];
    if (!lc && c + 1 < MAXC) begin
      win_energy[2] = line_energy[c + 1];
      win_marked[2] = line_marked[c + 1];
    end else begin
      win_energy[2] = INF;
      win_marked[2] = 1'b1;
    end

    total  = INF;
    parent = NO_PARENT;
    if (row_cnt == 0) begin
      total = marked ? INF : reg_margin;
    end else if (!marked) begin
      // preference: above, above-right, above-left; strict less-than
      best  = INF;
      found = 1'b0;
      if (!win_marked[1] && win_energy[1] < best) begin
        best = win_energy[1]; parent = PARENT_W'(c); found = 1'b1;
      end
      if (!lc && !win_marked[2] && win_energy[2] < best) begin
        best = win_energy[2]; parent = PARENT_W'(c + 1); found = 1'b1;
      end
      if (c > 0 && !win_marked[0] && win_energy[0] < best) begin
        best = win_energy[0]; parent = PARENT_W'(c - 1); found = 1'b1;
      end
      if (found) total = (e_ext >= INF - best) ? INF - 1 : best + e_ext;
    end

    win_energy[0]   = win_energy[1];
    win_marked[0]   = win_marked[1];
    line_energy[c]  = total;
    line_marked[c]  = marked;
    line_written[c] = 1'b1;

    r.total  = total;
    r.parent = parent;
    r.last   = lc && lr;

    if (lc) begin
      col_cnt = 0;
      row_cnt = lr ? 0 : row_cnt + 1;
    end else begin
      col_cnt = c + 1;
    end
    return r;
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_energy();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return PIXEL_W'($urandom_range(0, 3));   // small values make ties
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed table builders
  // --------------------------------------------------------------------------
  function automatic void add_pixel(input logic [PIXEL_W-1:0] energy, input bit marked);
    plan_row_t r;
    r        = '{kind: ROW_PIXEL, default: '0};
    r.kind   = ROW_PIXEL;
    r.energy = energy;
    r.marked = marked;
    plan.push_back(r);
  endfunction

  function automatic void add_checked(input logic [PIXEL_W-1:0] energy, input bit marked,
                                      input logic [EW-1:0] total,
                                      input logic [PARENT_W-1:0] parent, input bit last);
    plan_row_t r;
    r        = '{kind: ROW_PIXEL, default: '0};
    r.kind   = ROW_PIXEL;
    r.energy = energy;
    r.marked = marked;
    r.typed  = 1'b1;
    r.want   = '{total: total, parent: parent, last: last};
    plan.push_back(r);
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] index,
                                    input logic [CFG_DATA_W-1:0] value);
    plan_row_t r;
    r       = '{kind: ROW_WRITE, default: '0};
    r.kind  = ROW_WRITE;
    r.index = index;
    r.value = value;
    plan.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Drain every expected result, then let the pipeline go quiet.
  task automatic settle();
    px_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    if (!cfg_held) settle();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    cfg_held  = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_NUM_COLUMNS:   reg_cols   = value[NCOL_W-1:0];
      REG_NUM_ROWS:      reg_rows   = value[NROW_W-1:0];
      REG_MARGIN_ENERGY: reg_margin = value[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [PIXEL_W-1:0] energy, input bit marked,
                            input bit typed, input seam_result_t want);
    seam_result_t predicted;
    int unsigned  gap;
    if (cfg_held) begin
      cfg_valid <= 1'b0;
      cfg_held  = 1'b0;
    end
    if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      px_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    px_valid  <= 1'b1;
    px_data   <= energy;
    px_marked <= marked;
    do @(posedge clk); while (!px_ready);
    predicted = predict_path(energy, marked);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, none in the calm tail
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (calm || !idle_on) begin
      res_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_ready  <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      res_ready  <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Checker: each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: total_energy %h parent_column %0d",
               res_data[EW-1:0], $signed(res_data[EW +: PARENT_W]));
        mismatches++;
      end else begin
        want_now = pending_results.pop_front();
        if (res_data[EW-1:0] !== want_now.total) begin
          $error("total_energy: expected %h, got %h", want_now.total, res_data[EW-1:0]);
          mismatches++;
        end
        if (res_data[EW +: PARENT_W] !== want_now.parent) begin
          $error("parent_column: expected %0d, got %0d", $signed(want_now.parent),
                 $signed(res_data[EW +: PARENT_W]));
          mismatches++;
        end
        if (res_last !== want_now.last) begin
          $error("frame_last: expected %0b, got %0b", want_now.last, res_last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("seam_cumulative_energy: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned         sent_random, n, mark_pct;
    logic [NCOL_W-1:0]   new_cols;
    logic [NROW_W-1:0]   new_rows;
    logic [MARGIN_W-1:0] new_margin;
    sent_random = 0;
    for (int i = 0; i < 3; i++) begin
      win_energy[i] = INF;
      win_marked[i] = 1'b1;
    end

    // Right after reset: default registers, top row, margin zero
    add_checked(16'h0000, 1'b0, '0, NO_PARENT, 1'b0);
    add_checked(16'hFFFF, 1'b1, INF, NO_PARENT, 1'b0);
    add_checked(16'hFFFF, 1'b0, '0, NO_PARENT, 1'b0);
    add_checked(16'h0001, 1'b0, '0, NO_PARENT, 1'b0);
    // Shrink mid-row: counter sits past the new last column and wraps
    add_write(REG_NUM_ROWS, 2);
    add_write(REG_NUM_COLUMNS, 3);
    add_pixel(16'h0005, 1'b0);
    add_pixel(16'h0007, 1'b0);        // above wins, above-right marked
    add_pixel(16'h0003, 1'b0);        // above marked, tie on above-left loses
    add_pixel(16'hFFFF, 1'b1);        // marked pixel, frame end
    // Margin at infinity: top row infinite, next row has no reachable parent
    add_write(REG_MARGIN_ENERGY, INF);
    add_checked(16'h0009, 1'b0, INF, NO_PARENT, 1'b0);
    add_checked(16'h0000, 1'b0, INF, NO_PARENT, 1'b0);
    add_checked(16'h0000, 1'b1, INF, NO_PARENT, 1'b0);
    add_pixel(16'h0002, 1'b0);
    add_pixel(16'h0000, 1'b0);
    add_checked(16'h0000, 1'b0, INF, NO_PARENT, 1'b1);
    // Saturation just below infinity, one-column rows
    add_write(REG_MARGIN_ENERGY, 32'hFFFF_FFF0);
    add_write(REG_NUM_COLUMNS, 1);
    add_checked(16'h0000, 1'b0, 32'hFFFF_FFF0, NO_PARENT, 1'b0);
    add_checked(16'hFFFF, 1'b0, INF - 1, '0, 1'b1);
    // Zero registers act as one: every pixel is a frame of its own
    add_write(REG_NUM_COLUMNS, 0);
    add_write(REG_NUM_ROWS, 0);
    add_write(REG_MARGIN_ENERGY, 64);
    add_checked(16'h0008, 1'b0, 64, NO_PARENT, 1'b1);
    add_checked(16'h0008, 1'b1, INF, NO_PARENT, 1'b1);
    // Register maxima; columns above the buffer size clamp to it
    add_write(REG_NUM_COLUMNS, 13'h1FFF);
    add_write(REG_NUM_ROWS, 16'hFFFF);
    add_write(REG_MARGIN_ENERGY, 32'hFFFF_FFFE);
    add_checked(16'h1234, 1'b0, 32'hFFFF_FFFE, NO_PARENT, 1'b0);
    add_checked(16'hABCD, 1'b0, 32'hFFFF_FFFE, NO_PARENT, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].index, plan[i].value);
      else send_pixel(plan[i].energy, plan[i].marked, plan[i].typed, plan[i].want);
    end

    // Random phases: register changes at idle points, then a burst of pixels
    while (sent_random < RANDOM_PIXELS) begin
      calm    = (sent_random + CALM_PIXELS >= RANDOM_PIXELS);
      idle_on = !calm && ($urandom_range(0, 3) != 0);

      if ($urandom_range(0, 4) < 3) begin
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 19))
            0:             new_cols = 0;
            1:             new_cols = NCOL_W'($urandom_range(MAXC + 1, 8191));
            2, 3, 4, 5:    new_cols = NCOL_W'($urandom_range(7, 40));
            default:       new_cols = NCOL_W'($urandom_range(1, 6));
          endcase
          if (cols_ok(new_cols)) write_reg(REG_NUM_COLUMNS, new_cols);
        end
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 19))
            0:             new_rows = 0;
            1:             new_rows = 16'hFFFF;
            2:             new_rows = NROW_W'($urandom);
            3, 4, 5, 6:    new_rows = NROW_W'($urandom_range(5, 20));
            default:       new_rows = NROW_W'($urandom_range(1, 4));
          endcase
          write_reg(REG_NUM_ROWS, new_rows);
        end
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3:    new_margin = $urandom_range(0, 1000);
            4, 5:          new_margin = INF - $urandom_range(0, 131071);
            6:             new_margin = INF;
            7:             new_margin = INF - 1;
            default:       new_margin = $urandom;
          endcase
          write_reg(REG_MARGIN_ENERGY, new_margin);
        end
      end

      // Mostly sparse marks; now and then a noisy phase with half marked
      mark_pct = ($urandom_range(0, 5) == 0) ? 50 : 12;
      n        = $urandom_range(1, 48);
      repeat (n) begin
        if (sent_random < RANDOM_PIXELS) begin
          send_pixel(pick_energy(), $urandom_range(0, 99) < mark_pct, 1'b0, '0);
          sent_random++;
        end
      end
    end

    calm = 1'b1;
    settle();
    if (mismatches == 0) begin
      $display("seam_cumulative_energy: match");
    end else begin
      $display("seam_cumulative_energy: mismatch");
    end
    $finish;
  end

endmodule : tb_seam_cumulative_energy

`default_nettype wire
